@@ hdl/gdda_pkg.sv @@
package gdda_pkg;

    // Field widths fixed by the external interface
    localparam int COORD_W = 6;
    localparam int POS_W   = 8;
    localparam int EXT_W   = 7;
    localparam int PDIST_W = 24;

    // Command queue between the front and the back
    localparam int QDEPTH = 2;

    localparam logic [EXT_W-1:0] EXT_RESET = 7'd64;
    localparam logic OPC_CAST = 1'b1;

    typedef enum logic {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } gdda_reg_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_DROP  = 2'd1,
        OP_CAST  = 2'd2
    } gdda_op_t;

    typedef struct packed {
        gdda_op_t             op;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic                 wall;
        logic                 neg_x;
        logic                 neg_y;
        logic [PDIST_W-1:0]   side_x;
        logic [PDIST_W-1:0]   side_y;
        logic [PDIST_W-1:0]   delta_x;
        logic [PDIST_W-1:0]   delta_y;
    } gdda_item_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } gdda_bk_ctl_t;

endpackage

@@ hdl/gdda_front.sv @@
module gdda_front #(
    parameter int MAP_SIDE = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [gdda_pkg::COORD_W-1:0]   cell_x,
    input  logic [gdda_pkg::COORD_W-1:0]   cell_y,
    input  logic                           cell_is_wall,
    input  logic signed [1:0]              step_x,
    input  logic signed [1:0]              step_y,
    input  logic [gdda_pkg::PDIST_W-1:0]   ray_side_x,
    input  logic [gdda_pkg::PDIST_W-1:0]   ray_side_y,
    input  logic [gdda_pkg::PDIST_W-1:0]   ray_delta_x,
    input  logic [gdda_pkg::PDIST_W-1:0]   ray_delta_y,
    output logic                           head_valid,
    output gdda_pkg::gdda_item_t           head,
    input  gdda_pkg::gdda_bk_ctl_t         bk_ctl
);
    import gdda_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    gdda_item_t        item_in;
    gdda_item_t        q_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    // Classify: cast, map write, or write outside the store
    always_comb
    begin
        item_in.x       = cell_x;
        item_in.y       = cell_y;
        item_in.wall    = cell_is_wall;
        item_in.neg_x   = step_x[1];
        item_in.neg_y   = step_y[1];
        item_in.side_x  = ray_side_x;
        item_in.side_y  = ray_side_y;
        item_in.delta_x = ray_delta_x;
        item_in.delta_y = ray_delta_y;
        priority if (opcode == OPC_CAST)
            item_in.op = OP_CAST;
        else if (int'(cell_x) < MAP_SIDE && int'(cell_y) < MAP_SIDE)
            item_in.op = OP_WRITE;
        else
            item_in.op = OP_DROP;
    end

    assign in_ready   = (count_reg != CNT_W'(QDEPTH)) && !bk_ctl.clearing;
    assign push       = in_valid && in_ready;
    assign pop        = bk_ctl.pop;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= item_in;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctl.clearing |-> !push)
        else $error("transaction taken during map clear");

endmodule

@@ hdl/gdda_walk.sv @@
module gdda_walk #(
    parameter int MAP_SIDE  = 64,
    parameter int DIST_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 head_valid,
    input  gdda_pkg::gdda_item_t                 head,
    output gdda_pkg::gdda_bk_ctl_t               bk_ctl,
    input  logic [gdda_pkg::EXT_W-1:0]           map_width_cfg,
    input  logic [gdda_pkg::EXT_W-1:0]           map_height_cfg,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [gdda_pkg::POS_W-1:0]    hit_x,
    output logic signed [gdda_pkg::POS_W-1:0]    hit_y,
    output logic                                 hit_side,
    output logic [gdda_pkg::PDIST_W-1:0]         wall_distance,
    output logic                                 out_of_bounds
);
    import gdda_pkg::*;

    localparam int DEPTH   = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int EXT_CAP = (MAP_SIDE < 127) ? MAP_SIDE : 127;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t                    state_reg;
    logic [ADDR_W-1:0]         clr_addr_reg;
    logic signed [POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic                      neg_x_reg, neg_y_reg, side_reg;
    logic [DIST_BITS-1:0]      side_x_reg, side_y_reg, delta_x_reg, delta_y_reg;

    logic                      out_valid_reg, hit_side_reg, oob_reg;
    logic signed [POS_W-1:0]   hit_x_reg, hit_y_reg;
    logic [PDIST_W-1:0]        dist_reg;

    logic                      mem [DEPTH];
    logic                      rd_data_reg;
    logic                      mem_we, mem_wdata, rd_en;
    logic [ADDR_W-1:0]         mem_waddr, rd_addr;

    // Step datapath sources: queue head on the first step, walk registers after
    logic signed [POS_W-1:0]   cur_x, cur_y, inc_x, inc_y, nx, ny;
    logic [DIST_BITS-1:0]      cur_sx, cur_sy, cur_dx, cur_dy, nsx, nsy;
    logic                      cur_neg_x, cur_neg_y, take_x;
    logic [DIST_BITS:0]        sum_x, sum_y;

    logic [EXT_W-1:0]          ext_w, ext_h;
    logic                      outside, hit, out_free, step_en, is_cast, finish_walk;
    logic [DIST_BITS-1:0]      sel_side, sel_delta, diff, res_gap;

    assign is_cast = (state_reg == ST_IDLE) && head_valid && (head.op == OP_CAST);

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            cur_x     = $signed({{(POS_W-COORD_W){1'b0}}, head.x});
            cur_y     = $signed({{(POS_W-COORD_W){1'b0}}, head.y});
            cur_sx    = DIST_BITS'(head.side_x);
            cur_sy    = DIST_BITS'(head.side_y);
            cur_dx    = DIST_BITS'(head.delta_x);
            cur_dy    = DIST_BITS'(head.delta_y);
            cur_neg_x = head.neg_x;
            cur_neg_y = head.neg_y;
        end
        else
        begin
            cur_x     = pos_x_reg;
            cur_y     = pos_y_reg;
            cur_sx    = side_x_reg;
            cur_sy    = side_y_reg;
            cur_dx    = delta_x_reg;
            cur_dy    = delta_y_reg;
            cur_neg_x = neg_x_reg;
            cur_neg_y = neg_y_reg;
        end
    end

    // Advance the smaller side distance; a tie advances y
    always_comb
    begin
        take_x = cur_sx < cur_sy;
        inc_x  = cur_neg_x ? {POS_W{1'b1}} : POS_W'(1);
        inc_y  = cur_neg_y ? {POS_W{1'b1}} : POS_W'(1);
        sum_x  = {1'b0, cur_sx} + {1'b0, cur_dx};
        sum_y  = {1'b0, cur_sy} + {1'b0, cur_dy};
        nx     = take_x ? cur_x + inc_x : cur_x;
        ny     = take_x ? cur_y : cur_y + inc_y;
        nsx    = !take_x ? cur_sx : (sum_x[DIST_BITS] ? DIST_MAX : sum_x[DIST_BITS-1:0]);
        nsy    = take_x ? cur_sy : (sum_y[DIST_BITS] ? DIST_MAX : sum_y[DIST_BITS-1:0]);
    end

    assign rd_addr = ADDR_W'(ny[EXT_W-1:0]) * ADDR_W'(MAP_SIDE) + ADDR_W'(nx[EXT_W-1:0]);

    // Test of the cell reached by the last step
    assign ext_w = (map_width_cfg > EXT_W'(EXT_CAP)) ? EXT_W'(EXT_CAP) : map_width_cfg;
    assign ext_h = (map_height_cfg > EXT_W'(EXT_CAP)) ? EXT_W'(EXT_CAP) : map_height_cfg;

    assign outside = pos_x_reg[POS_W-1] || pos_y_reg[POS_W-1]
                  || (pos_x_reg[EXT_W-1:0] >= ext_w) || (pos_y_reg[EXT_W-1:0] >= ext_h);
    assign hit         = outside || rd_data_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign step_en     = is_cast || ((state_reg == ST_WALK) && !hit);
    assign rd_en       = step_en;
    assign finish_walk = (state_reg == ST_WALK) && hit && out_free;

    assign sel_side  = side_reg ? side_y_reg : side_x_reg;
    assign sel_delta = side_reg ? delta_y_reg : delta_x_reg;
    assign diff      = (sel_side >= sel_delta) ? sel_side - sel_delta : '0;
    assign res_gap   = outside ? DIST_MAX : diff;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(head.y) * ADDR_W'(MAP_SIDE) + ADDR_W'(head.x);
        mem_wdata = head.wall;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 1'b0;
        end
        else if (state_reg == ST_IDLE && head_valid && head.op == OP_WRITE)
            mem_we = 1'b1;
    end

    assign bk_ctl.pop      = (state_reg == ST_IDLE) && head_valid;
    assign bk_ctl.clearing = (state_reg == ST_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            neg_x_reg     <= 1'b0;
            neg_y_reg     <= 1'b0;
            side_reg      <= 1'b0;
            side_x_reg    <= '0;
            side_y_reg    <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_x_reg     <= '0;
            hit_y_reg     <= '0;
            hit_side_reg  <= 1'b0;
            dist_reg      <= '0;
            oob_reg       <= 1'b0;
        end
        else
        begin
            if (finish_walk)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (step_en)
            begin
                pos_x_reg  <= nx;
                pos_y_reg  <= ny;
                side_x_reg <= nsx;
                side_y_reg <= nsy;
                side_reg   <= !take_x;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                        state_reg <= ST_IDLE;
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                end
                ST_IDLE:
                begin
                    if (is_cast)
                    begin
                        delta_x_reg <= cur_dx;
                        delta_y_reg <= cur_dy;
                        neg_x_reg   <= cur_neg_x;
                        neg_y_reg   <= cur_neg_y;
                        state_reg   <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    // Hold the finished walk until the result slot frees up
                    if (finish_walk)
                    begin
                        hit_x_reg     <= pos_x_reg;
                        hit_y_reg     <= pos_y_reg;
                        hit_side_reg  <= side_reg;
                        dist_reg      <= PDIST_W'(res_gap);
                        oob_reg       <= outside;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign hit_x         = hit_x_reg;
    assign hit_y         = hit_y_reg;
    assign hit_side      = hit_side_reg;
    assign wall_distance = dist_reg;
    assign out_of_bounds = oob_reg;

    a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !bk_ctl.pop)
        else $error("queue popped during map clear");

    a_walk_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> !mem_we)
        else $error("map written during a walk");

    a_oob_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && oob_reg |-> dist_reg == PDIST_W'(DIST_MAX))
        else $error("out of bounds result without saturated distance");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        finish_walk |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished walk did not deliver its result");

endmodule

@@ hdl/grid_ray_dda_traversal.sv @@
// Grid ray DDA traversal over a MAP_SIDE x MAP_SIDE wall map; a 2-entry queue feeds the walker.
// A map write is queued, then written to the store when it reaches the idle walker; a cast is
// queued, then walks the map from its start cell, and its result is registered for the receiver.
// Throughput: one cell step per cycle during a walk; writes retire one per cycle while no
// walk is in progress. Reset: map_width and map_height return to 64, then the map clears one
// cell per cycle with in_ready low.
module grid_ray_dda_traversal #(
    parameter int MAP_SIDE  = 64,
    parameter int DIST_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_data,

    // Input item channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [5:0]           cell_x,
    input  logic [5:0]           cell_y,
    input  logic                 cell_is_wall,
    input  logic signed [1:0]    step_x,
    input  logic signed [1:0]    step_y,
    input  logic [23:0]          ray_side_x,
    input  logic [23:0]          ray_side_y,
    input  logic [23:0]          ray_delta_x,
    input  logic [23:0]          ray_delta_y,

    // Result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [7:0]    hit_x,
    output logic signed [7:0]    hit_y,
    output logic                 hit_side,
    output logic [23:0]          wall_distance,
    output logic                 out_of_bounds
);
    import gdda_pkg::*;

    logic [EXT_W-1:0]  map_width_reg, map_height_reg;
    logic              head_valid;
    gdda_item_t        head;
    gdda_bk_ctl_t      bk_ctl;

    // Config registers are always writable; software is to write them only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= EXT_RESET;
            map_height_reg <= EXT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gdda_reg_t'(cfg_index))
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                REG_MAP_HEIGHT: map_height_reg <= cfg_data;
            endcase
        end
    end

    // Front: accept each transaction, classify it and queue it
    gdda_front #(
        .MAP_SIDE (MAP_SIDE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_is_wall (cell_is_wall),
        .step_x       (step_x),
        .step_y       (step_y),
        .ray_side_x   (ray_side_x),
        .ray_side_y   (ray_side_y),
        .ray_delta_x  (ray_delta_x),
        .ray_delta_y  (ray_delta_y),
        .head_valid   (head_valid),
        .head         (head),
        .bk_ctl       (bk_ctl)
    );

    // Back: map store, cell walker and result register
    gdda_walk #(
        .MAP_SIDE  (MAP_SIDE),
        .DIST_BITS (DIST_BITS)
    ) u_walk (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .bk_ctl         (bk_ctl),
        .map_width_cfg  (map_width_reg),
        .map_height_cfg (map_height_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit_x          (hit_x),
        .hit_y          (hit_y),
        .hit_side       (hit_side),
        .wall_distance  (wall_distance),
        .out_of_bounds  (out_of_bounds)
    );

    a_reset_extents: assert property (@(posedge clk)
        !rst_n |=> map_width_reg == EXT_RESET && map_height_reg == EXT_RESET)
        else $error("extents not restored by reset");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctl.clearing |-> !in_ready)
        else $error("input ready during map clear");

    a_cfg_takes_effect: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == REG_MAP_WIDTH |=> map_width_reg == $past(cfg_data))
        else $error("map width write lost");

endmodule

@@ bench/grid_ray_dda_traversal_test.sv @@
`timescale 1ns / 1ps

module grid_ray_dda_traversal_test;

    import gdda_pkg::*;

    localparam int          MAP_SIDE     = 64;
    localparam int          IDLE_PCT     = 20;
    // Let queued map writes retire before touching the extent registers.
    localparam int          SETTLE_CYCLES = 8;
    // Longest walk is about width + height cells.
    localparam int          DRAIN_CYCLES = 140;
    localparam longint      CYCLE_LIMIT  = 2_000_000;
    localparam logic [23:0] DIST_MAX     = 24'hFF_FFFF;

    localparam logic OPC_WRITE = 1'b0;

    // Step field encodings: only the sign bit matters to the walker.
    localparam logic [1:0] STEP_FWD  = 2'b01;
    localparam logic [1:0] STEP_BACK = 2'b11;
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_MIN  = 2'b10;

    typedef struct packed {
        logic        opc;
        logic [5:0]  x;
        logic [5:0]  y;
        logic        wall;
        logic [1:0]  stx;
        logic [1:0]  sty;
        logic [23:0] sdx;
        logic [23:0] sdy;
        logic [23:0] ddx;
        logic [23:0] ddy;
    } grid_cmd_t;

    typedef struct packed {
        logic [7:0]  hx;
        logic [7:0]  hy;
        logic        side;
        logic [23:0] gap;
        logic        oob;
    } ray_hit_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic               cfg_index     = 1'b0;
    logic [6:0]         cfg_data      = '0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic               opcode        = 1'b0;
    logic [5:0]         cell_x        = '0;
    logic [5:0]         cell_y        = '0;
    logic               cell_is_wall  = 1'b0;
    logic signed [1:0]  step_x        = '0;
    logic signed [1:0]  step_y        = '0;
    logic [23:0]        ray_side_x    = '0;
    logic [23:0]        ray_side_y    = '0;
    logic [23:0]        ray_delta_x   = '0;
    logic [23:0]        ray_delta_y   = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic signed [7:0]  hit_x;
    logic signed [7:0]  hit_y;
    logic               hit_side;
    logic [23:0]        wall_distance;
    logic               out_of_bounds;

    // Shadow copy of the block's state, updated at each accepted transaction.
    bit                 wall_cells [0:MAP_SIDE*MAP_SIDE-1];
    logic [6:0]         width_setting  = EXT_RESET;
    logic [6:0]         height_setting = EXT_RESET;

    ray_hit_t           expected_hits [$];
    int                 fault_count   = 0;
    longint             cycle_count   = 0;
    // Set during a phase that runs both sides with no idling at all.
    bit                 steady        = 1'b0;

    grid_ray_dda_traversal u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .cell_is_wall  (cell_is_wall),
        .step_x        (step_x),
        .step_y        (step_y),
        .ray_side_x    (ray_side_x),
        .ray_side_y    (ray_side_y),
        .ray_delta_x   (ray_delta_x),
        .ray_delta_y   (ray_delta_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit_x         (hit_x),
        .hit_y         (hit_y),
        .hit_side      (hit_side),
        .wall_distance (wall_distance),
        .out_of_bounds (out_of_bounds)
    );

    always #5 clk = ~clk;

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: stall about one cycle in five, never while the steady phase runs.
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    task automatic flag_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
            flag_fault($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    endtask

    // Result checker: compare every result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        ray_hit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
                flag_fault($sformatf("unexpected result: hit (%0d,%0d)", hit_x, hit_y));
            else
            begin
                want = expected_hits.pop_front();
                check_field("hit_x", 24'(want.hx), 24'($unsigned(hit_x)));
                check_field("hit_y", 24'(want.hy), 24'($unsigned(hit_y)));
                check_field("hit_side", 24'(want.side), 24'(hit_side));
                check_field("wall_distance", want.gap, wall_distance);
                check_field("out_of_bounds", 24'(want.oob), 24'(out_of_bounds));
            end
        end
    end

    function automatic int usable_extent(input logic [6:0] setting);
        return (setting > 7'(MAP_SIDE)) ? MAP_SIDE : int'(setting);
    endfunction

    // Walk the grid cell by cell until a wall or the edge of the active area.
    function automatic ray_hit_t trace_ray(input grid_cmd_t c);
        int              x, y, sx, sy, w, h;
        longint unsigned acc_x, acc_y, dx, dy, gap_val;
        bit              side, gone, done;
        ray_hit_t        r;
        x     = int'(c.x);
        y     = int'(c.y);
        sx    = c.stx[1] ? -1 : 1;
        sy    = c.sty[1] ? -1 : 1;
        acc_x = c.sdx;
        acc_y = c.sdy;
        dx    = c.ddx;
        dy    = c.ddy;
        w     = usable_extent(width_setting);
        h     = usable_extent(height_setting);
        side  = 1'b0;
        gone  = 1'b0;
        done  = 1'b0;
        while (!done)
        begin
            // A tie advances the y axis.
            if (acc_x < acc_y)
            begin
                acc_x = (acc_x + dx > DIST_MAX) ? DIST_MAX : acc_x + dx;
                x     = x + sx;
                side  = 1'b0;
            end
            else
            begin
                acc_y = (acc_y + dy > DIST_MAX) ? DIST_MAX : acc_y + dy;
                y     = y + sy;
                side  = 1'b1;
            end
            if (x < 0 || x >= w || y < 0 || y >= h)
            begin
                gone = 1'b1;
                done = 1'b1;
            end
            else if (wall_cells[y*MAP_SIDE + x])
                done = 1'b1;
        end
        if (gone)
            gap_val = DIST_MAX;
        else if (side)
            gap_val = (acc_y >= dy) ? acc_y - dy : 0;
        else
            gap_val = (acc_x >= dx) ? acc_x - dx : 0;
        r.hx   = x[7:0];
        r.hy   = y[7:0];
        r.side = side;
        r.gap  = gap_val[23:0];
        r.oob  = gone;
        return r;
    endfunction

    // Hold the input channel idle until every expected result is back,
    // then give queued map writes time to retire.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input gdda_reg_t idx, input logic [6:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MAP_WIDTH)
            width_setting = value;
        else
            height_setting = value;
    endtask

    // Send one item transaction. Valid is left high after acceptance so that a
    // back-to-back item does not lower and raise it in the same step.
    task automatic issue_cmd(input grid_cmd_t c);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= c.opc;
        cell_x       <= c.x;
        cell_y       <= c.y;
        cell_is_wall <= c.wall;
        step_x       <= c.stx;
        step_y       <= c.sty;
        ray_side_x   <= c.sdx;
        ray_side_y   <= c.sdy;
        ray_delta_x  <= c.ddx;
        ray_delta_y  <= c.ddy;
        do @(posedge clk); while (!in_ready);
        if (c.opc == OPC_CAST)
            expected_hits.push_back(trace_ray(c));
        else
            wall_cells[int'(c.y)*MAP_SIDE + int'(c.x)] = c.wall;
    endtask

    function automatic grid_cmd_t make_write(input logic [5:0] x, input logic [5:0] y,
                                             input logic wall);
        grid_cmd_t c;
        c      = '0;
        c.opc  = OPC_WRITE;
        c.x    = x;
        c.y    = y;
        c.wall = wall;
        return c;
    endfunction

    function automatic grid_cmd_t make_cast(input logic [5:0] x, input logic [5:0] y,
                                            input logic [1:0] stx, input logic [1:0] sty,
                                            input logic [23:0] sdx, input logic [23:0] sdy,
                                            input logic [23:0] ddx, input logic [23:0] ddy);
        grid_cmd_t c;
        c     = '0;
        c.opc = OPC_CAST;
        c.x   = x;
        c.y   = y;
        c.stx = stx;
        c.sty = sty;
        c.sdx = sdx;
        c.sdy = sdy;
        c.ddx = ddx;
        c.ddy = ddy;
        return c;
    endfunction

    // Mostly land inside the active area; sometimes anywhere in the store.
    function automatic logic [5:0] pick_coord(input logic [6:0] extent);
        int lim;
        lim = usable_extent(extent);
        if (lim == 0 || $urandom_range(0, 99) < 15)
            return 6'($urandom_range(0, MAP_SIDE - 1));
        return 6'($urandom_range(0, lim - 1));
    endfunction

    // Typical deltas stay at or below 4.0; a few are zero or span the full width.
    function automatic logic [23:0] pick_delta();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 24'($urandom_range(0, 24'h4_0000));
        if (r == 7)
            return '0;
        return 24'($urandom);
    endfunction

    function automatic logic [23:0] pick_side(input logic [23:0] delta);
        if ($urandom_range(0, 9) < 8)
            return 24'($urandom_range(0, delta));
        return 24'($urandom);
    endfunction

    // Empty map at the reset extents: rays run off the edges.
    task automatic test_open_map();
        // Zero deltas and a tie at the corner: y goes first and leaves at once.
        issue_cmd(make_cast(6'd0, 6'd0, STEP_BACK, STEP_BACK, '0, '0, '0, '0));
        issue_cmd(make_cast(6'd63, 6'd63, STEP_FWD, STEP_FWD,
                            24'h00_8000, 24'h01_0000, 24'h01_0000, 24'h01_0000));
    endtask

    task automatic test_wall_hits();
        issue_cmd(make_write(6'd10, 6'd5, 1'b1));
        // Wall on the start cell itself must be skipped.
        issue_cmd(make_write(6'd5, 6'd5, 1'b1));
        issue_cmd(make_cast(6'd5, 6'd5, STEP_FWD, STEP_BACK,
                            24'h00_4000, DIST_MAX, 24'h01_0000, 24'h02_0000));
        // Zero and minus-two step fields, saturated accumulators tying every step.
        issue_cmd(make_write(6'd7, 6'd2, 1'b1));
        issue_cmd(make_cast(6'd7, 6'd5, STEP_ZERO, STEP_MIN,
                            DIST_MAX, DIST_MAX, 24'h01_0000, 24'h01_0000));
        issue_cmd(make_write(6'd63, 6'd63, 1'b1));
        issue_cmd(make_write(6'd0, 6'd0, 1'b1));
        issue_cmd(make_cast(6'd60, 6'd63, STEP_FWD, STEP_FWD,
                            '0, 24'h10_0000, 24'h00_8000, 24'h10_0000));
        // Clear the first wall and cast the same ray again: it now escapes.
        issue_cmd(make_write(6'd10, 6'd5, 1'b0));
        issue_cmd(make_cast(6'd5, 6'd5, STEP_FWD, STEP_BACK,
                            24'h00_4000, DIST_MAX, 24'h01_0000, 24'h02_0000));
        issue_cmd(make_cast(6'd32, 6'd32, STEP_FWD, STEP_FWD,
                            24'hFF_FFF0, DIST_MAX, DIST_MAX, DIST_MAX));
        issue_cmd(make_cast(6'd1, 6'd1, STEP_BACK, STEP_BACK,
                            24'h00_0100, 24'h00_0100, 24'h00_0000, 24'hAA_5555));
    endtask

    // Extent registers at zero, above the store size, and below the start cell.
    task automatic test_extent_registers();
        write_reg(REG_MAP_WIDTH, 7'd0);
        issue_cmd(make_cast(6'd3, 6'd3, STEP_FWD, STEP_FWD,
                            24'h01_0000, 24'h00_1000, 24'h01_0000, 24'h01_0000));
        write_reg(REG_MAP_WIDTH, 7'd127);
        write_reg(REG_MAP_HEIGHT, 7'd0);
        issue_cmd(make_cast(6'd3, 6'd3, STEP_FWD, STEP_FWD,
                            24'h00_1000, 24'h01_0000, 24'h01_0000, 24'h01_0000));
        write_reg(REG_MAP_WIDTH, 7'd1);
        write_reg(REG_MAP_HEIGHT, 7'd65);
        issue_cmd(make_cast(6'd0, 6'd10, STEP_FWD, STEP_FWD,
                            '0, 24'h01_0000, 24'h01_0000, 24'h01_0000));
        write_reg(REG_MAP_WIDTH, 7'd4);
        write_reg(REG_MAP_HEIGHT, 7'd4);
        // Start cell well outside the 4x4 area.
        issue_cmd(make_cast(6'd40, 6'd40, STEP_BACK, STEP_BACK,
                            '0, '0, 24'h01_0000, 24'h01_0000));
        issue_cmd(make_write(6'd3, 6'd1, 1'b1));
        issue_cmd(make_cast(6'd1, 6'd1, STEP_FWD, STEP_BACK,
                            '0, 24'h80_0000, 24'h00_2000, 24'h01_0000));
    endtask

    // Random traffic at one extent setting: mostly casts over a map that the
    // writes keep reshaping, with a little fully random noise.
    task automatic test_random_phase(input logic [6:0] w, input logic [6:0] h,
                                     input int n_items, input int wall_pct,
                                     input bit calm);
        grid_cmd_t c;
        int        r;
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        steady = calm;
        for (int i = 0; i < n_items; i++)
        begin
            // Halfway through, let the block drain completely before going on.
            if (i == n_items / 2)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                c = grid_cmd_t'({$urandom, $urandom, $urandom, $urandom});
            end
            else if (r < 40)
                c = make_write(pick_coord(w), pick_coord(h),
                               $urandom_range(0, 99) < wall_pct);
            else
            begin
                c = make_cast(pick_coord(w), pick_coord(h),
                              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              '0, '0, pick_delta(), pick_delta());
                c.sdx = pick_side(c.ddx);
                c.sdy = pick_side(c.ddy);
            end
            issue_cmd(c);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_open_map();
        test_wall_hits();
        test_extent_registers();

        test_random_phase(7'd64, 7'd64, 400, 60, 1'b0);
        test_random_phase(7'd16, 7'd12, 300, 30, 1'b1);
        test_random_phase(7'd1, 7'd64, 100, 40, 1'b0);
        test_random_phase(7'd64, 7'd1, 100, 40, 1'b0);
        test_random_phase(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                          300, 35, 1'b0);
        test_random_phase(7'd0, 7'd33, 50, 50, 1'b0);
        test_random_phase(7'd100, 7'd127, 200, 20, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_hits.size() != 0)
            flag_fault($sformatf("%0d expected results never arrived",
                                 expected_hits.size()));
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ grid_ray_dda_traversal.f @@
hdl/gdda_pkg.sv
hdl/gdda_front.sv
hdl/gdda_walk.sv
hdl/grid_ray_dda_traversal.sv
bench/grid_ray_dda_traversal_test.sv
